// ===== rtl/blm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the battery level monitor
// no dependencies; every other rtl file refers to this package by scoped names
package blm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int RATIO_W    = 13;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // serial divider: quotient shift register, partial remainder, step count
  localparam int Q_W     = 12;
  localparam int REM_W   = 17;
  localparam int NBITS_W = 4;

  // serial multiplier and percentage numerator
  localparam int PROD_W   = SAMPLE_W + RATIO_W;
  localparam int SCALED_W = PROD_W - FRAC_W;
  localparam int NUM_W    = 24;

  localparam logic [NBITS_W-1:0] AVG_STEPS = 4'd12;
  localparam logic [NBITS_W-1:0] PCT_STEPS = 4'd7;
  localparam logic [NBITS_W-1:0] MUL_STEPS = 4'd13;

  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

  localparam logic [RATIO_W-1:0] RATIO_RST    = 13'd512;
  localparam logic [MV_W-1:0]    EMPTY_RST    = 16'd3300;
  localparam logic [MV_W-1:0]    FULL_RST     = 16'd4200;
  localparam logic [MV_W-1:0]    LOW_RST      = 16'd3500;
  localparam logic [MV_W-1:0]    CRITICAL_RST = 16'd3300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO    = 3'd0,
    CFG_EMPTY    = 3'd1,
    CFG_FULL     = 3'd2,
    CFG_LOW      = 3'd3,
    CFG_CRITICAL = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_AVG_GO,
    S_AVG,
    S_MUL,
    S_PREP,
    S_PCT_GO,
    S_PCT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [REM_W-1:0]   rem_init;
    logic [Q_W-1:0]     qin;
    logic [REM_W-1:0]   dvs;
    logic [NBITS_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] mcand;
    logic [RATIO_W-1:0]  mplr;
  } mul_req_t;

endpackage

// ===== rtl/blm_win.sv =====
`timescale 1ns / 1ps
// sample ring and running sum of the moving-average window
// depends on blm_pkg
module blm_win #(
  parameter int WINDOW_LEN = 16,
  parameter int SLOT_W     = 4,
  parameter int SUM_W      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [blm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          upd,
  output logic [SUM_W-1:0]              sum
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  logic [blm_pkg::SAMPLE_W-1:0] ring [WINDOW_LEN];
  logic [blm_pkg::SAMPLE_W-1:0] rd_r;
  logic [blm_pkg::SAMPLE_W-1:0] smp_r;
  logic [blm_pkg::SAMPLE_W-1:0] first_r, first_nxt;
  logic [blm_pkg::SAMPLE_W-1:0] old_val;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic                         primed_r, primed_nxt;
  logic                         filled_r, filled_nxt;

  // slots are written in order, so before the first wrap the slot ahead is unwritten
  assign old_val = filled_r ? rd_r : first_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r  <= ring[slot_r];
      smp_r <= in_sample;
    end
    if (upd) begin
      ring[slot_r] <= smp_r;
    end
  end

  always_comb begin
    sum_nxt    = sum_r;
    first_nxt  = first_r;
    slot_nxt   = slot_r;
    primed_nxt = primed_r;
    filled_nxt = filled_r;
    if (upd) begin
      if (!primed_r) begin
        // first sample stands for every slot
        sum_nxt   = SUM_W'(smp_r) * SUM_W'(WINDOW_LEN);
        first_nxt = smp_r;
      end else begin
        sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(smp_r);
      end
      primed_nxt = 1'b1;
      slot_nxt   = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
      filled_nxt = filled_r | (slot_r == LAST_SLOT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      first_r  <= '0;
      slot_r   <= '0;
      primed_r <= 1'b0;
      filled_r <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      first_r  <= first_nxt;
      slot_r   <= slot_nxt;
      primed_r <= primed_nxt;
      filled_r <= filled_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== rtl/blm_div.sv =====
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
// depends on blm_pkg; the caller preloads the upper dividend bits as remainder
module blm_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  blm_pkg::div_req_t        req,
  output logic                     done,
  output logic [blm_pkg::Q_W-1:0]  quot
);

  logic                         busy_r, busy_nxt;
  logic [blm_pkg::NBITS_W-1:0]  cnt_r, cnt_nxt;
  logic [blm_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [blm_pkg::REM_W-1:0]    dvs_r, dvs_nxt;
  logic [blm_pkg::Q_W-1:0]      q_r, q_nxt;
  logic [blm_pkg::REM_W:0]      trial;
  logic                         fits;

  // remainder stays below the divisor, so the top bit of the trial is the borrow
  assign trial = {rem_r, q_r[blm_pkg::Q_W-1]} - {1'b0, dvs_r};
  assign fits  = !trial[blm_pkg::REM_W];
  assign done  = busy_r && (cnt_r == '0);
  assign quot  = q_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      rem_nxt  = req.rem_init;
      dvs_nxt  = req.dvs;
      q_nxt    = req.qin;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        rem_nxt = fits ? trial[blm_pkg::REM_W-1:0]
                       : {rem_r[blm_pkg::REM_W-2:0], q_r[blm_pkg::Q_W-1]};
        q_nxt   = {q_r[blm_pkg::Q_W-2:0], fits};
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

endmodule

// ===== rtl/blm_mul.sv =====
`timescale 1ns / 1ps
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on blm_pkg
module blm_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  blm_pkg::mul_req_t           req,
  output logic                        done,
  output logic [blm_pkg::PROD_W-1:0]  prod
);

  logic                          busy_r, busy_nxt;
  logic [blm_pkg::NBITS_W-1:0]   cnt_r, cnt_nxt;
  logic [blm_pkg::PROD_W-1:0]    acc_r, acc_nxt;
  logic [blm_pkg::PROD_W-1:0]    mc_r, mc_nxt;
  logic [blm_pkg::RATIO_W-1:0]   mp_r, mp_nxt;

  assign done = busy_r && (cnt_r == '0);
  assign prod = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = blm_pkg::MUL_STEPS;
      acc_nxt  = '0;
      mc_nxt   = blm_pkg::PROD_W'(req.mcand);
      mp_nxt   = req.mplr;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        acc_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

endmodule

// ===== rtl/battery_level_monitor_core.sv =====
`timescale 1ns / 1ps
// battery level monitor top: config registers, sequencer and result register
// depends on blm_pkg, blm_win, blm_div, blm_mul
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready   | in_sample_mv
//  out     | output    | out_valid / out_ready | out_battery_mv, out_charge_percent,
//          |           |                       | out_is_low, out_is_critical
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// each item runs through the serial divider (12 steps for the average, 7 for the
// percentage, which is skipped when the percentage clamps) and the 13-step serial
// multiplier, one item in flight at a time.
// the next item is taken while a result still waits in the output register.
// cfg_ready is always high; reset is synchronous and restores register defaults.
module battery_level_monitor_core #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [blm_pkg::SAMPLE_W-1:0]    in_sample_mv,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [blm_pkg::MV_W-1:0]        out_battery_mv,
  output logic [blm_pkg::PCT_W-1:0]       out_charge_percent,
  output logic                            out_is_low,
  output logic                            out_is_critical,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W  = blm_pkg::SAMPLE_W + $clog2(WINDOW_LEN);

  blm_pkg::state_t state_r, state_nxt;

  logic [blm_pkg::RATIO_W-1:0] ratio_r;
  logic [blm_pkg::MV_W-1:0]    empty_r, full_r, low_mv_r, crit_mv_r;

  logic [SUM_W-1:0]               sum;
  logic                           in_fire;
  logic                           win_upd;
  blm_pkg::div_req_t              div_req;
  blm_pkg::mul_req_t              mul_req;
  logic                           div_done, mul_done;
  logic [blm_pkg::Q_W-1:0]        div_quot;
  logic [blm_pkg::PROD_W-1:0]     prod;
  logic [blm_pkg::SCALED_W-1:0]   scaled;
  logic [blm_pkg::MV_W-1:0]       sat_mv;
  logic [blm_pkg::NUM_W-1:0]      num;
  logic                           out_load;

  logic [blm_pkg::MV_W-1:0]  mv_r, diff_r, span_r;
  logic                      le_empty_r, ge_full_r, low_r, crit_r;
  logic [blm_pkg::PCT_W-1:0] pct_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [blm_pkg::MV_W-1:0]  out_mv_r;
  logic [blm_pkg::PCT_W-1:0] out_pct_r;
  logic                      out_low_r, out_crit_r;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r   <= blm_pkg::RATIO_RST;
      empty_r   <= blm_pkg::EMPTY_RST;
      full_r    <= blm_pkg::FULL_RST;
      low_mv_r  <= blm_pkg::LOW_RST;
      crit_mv_r <= blm_pkg::CRITICAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        blm_pkg::CFG_RATIO:    ratio_r   <= cfg_data[blm_pkg::RATIO_W-1:0];
        blm_pkg::CFG_EMPTY:    empty_r   <= cfg_data;
        blm_pkg::CFG_FULL:     full_r    <= cfg_data;
        blm_pkg::CFG_LOW:      low_mv_r  <= cfg_data;
        blm_pkg::CFG_CRITICAL: crit_mv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  blm_win #(
    .WINDOW_LEN (WINDOW_LEN),
    .SLOT_W     (SLOT_W),
    .SUM_W      (SUM_W)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_sample (in_sample_mv),
    .upd       (win_upd),
    .sum       (sum)
  );

  blm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  blm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (prod)
  );

  assign scaled = prod[blm_pkg::PROD_W-1:blm_pkg::FRAC_W];
  assign sat_mv = ((scaled >> blm_pkg::MV_W) != '0) ? '1 : scaled[blm_pkg::MV_W-1:0];

  // 200*diff + span, with 200 = 128 + 64 + 8
  assign num = (blm_pkg::NUM_W'(diff_r) << 7) + (blm_pkg::NUM_W'(diff_r) << 6)
             + (blm_pkg::NUM_W'(diff_r) << 3) + blm_pkg::NUM_W'(span_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      blm_pkg::S_IDLE:   if (in_fire) state_nxt = blm_pkg::S_SUM;
      blm_pkg::S_SUM:    state_nxt = blm_pkg::S_AVG_GO;
      blm_pkg::S_AVG_GO: state_nxt = blm_pkg::S_AVG;
      blm_pkg::S_AVG:    if (div_done) state_nxt = blm_pkg::S_MUL;
      blm_pkg::S_MUL:    if (mul_done) state_nxt = blm_pkg::S_PREP;
      blm_pkg::S_PREP:   state_nxt = blm_pkg::S_PCT_GO;
      blm_pkg::S_PCT_GO: begin
        state_nxt = (le_empty_r || ge_full_r) ? blm_pkg::S_DONE : blm_pkg::S_PCT;
      end
      blm_pkg::S_PCT:    if (div_done) state_nxt = blm_pkg::S_DONE;
      blm_pkg::S_DONE:   if (!out_valid_r || out_ready) state_nxt = blm_pkg::S_IDLE;
      default:           state_nxt = blm_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    win_upd  = 1'b0;
    div_req  = '0;
    mul_req  = '0;
    out_load = 1'b0;
    unique case (state_r)
      blm_pkg::S_IDLE: in_ready = 1'b1;
      blm_pkg::S_SUM:  win_upd = 1'b1;
      blm_pkg::S_AVG_GO: begin
        // sum < WINDOW_LEN * 4096, so the average fits in twelve quotient bits
        div_req.start    = 1'b1;
        div_req.rem_init = blm_pkg::REM_W'(sum >> blm_pkg::Q_W);
        div_req.qin      = sum[blm_pkg::Q_W-1:0];
        div_req.dvs      = blm_pkg::REM_W'(WINDOW_LEN);
        div_req.nbits    = blm_pkg::AVG_STEPS;
      end
      blm_pkg::S_AVG: begin
        mul_req.start = div_done;
        mul_req.mcand = div_quot;
        mul_req.mplr  = ratio_r;
      end
      blm_pkg::S_PCT_GO: begin
        // quotient stays below 128, so seven steps cover it
        div_req.start    = !(le_empty_r || ge_full_r);
        div_req.rem_init = blm_pkg::REM_W'(num >> blm_pkg::PCT_W);
        div_req.qin      = {num[blm_pkg::PCT_W-1:0], {(blm_pkg::Q_W - blm_pkg::PCT_W){1'b0}}};
        div_req.dvs      = {span_r, 1'b0};
        div_req.nbits    = blm_pkg::PCT_STEPS;
      end
      blm_pkg::S_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result datapath
  always_ff @(posedge clk) begin
    if (state_r == blm_pkg::S_MUL && mul_done) begin
      mv_r <= sat_mv;
    end
    if (state_r == blm_pkg::S_PREP) begin
      diff_r     <= mv_r - empty_r;
      span_r     <= full_r - empty_r;
      le_empty_r <= mv_r <= empty_r;
      ge_full_r  <= mv_r >= full_r;
      low_r      <= mv_r <= low_mv_r;
      crit_r     <= mv_r <= crit_mv_r;
    end
    if (state_r == blm_pkg::S_PCT_GO) begin
      pct_r <= le_empty_r ? blm_pkg::PCT_EMPTY : blm_pkg::PCT_FULL;
    end
    if (state_r == blm_pkg::S_PCT && div_done) begin
      pct_r <= div_quot[blm_pkg::PCT_W-1:0];
    end
    if (out_load) begin
      out_mv_r   <= mv_r;
      out_pct_r  <= pct_r;
      out_low_r  <= low_r;
      out_crit_r <= crit_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_battery_mv     = out_mv_r;
  assign out_charge_percent = out_pct_r;
  assign out_is_low         = out_low_r;
  assign out_is_critical    = out_crit_r;

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charge_percent <= blm_pkg::PCT_FULL)
    else $error("charge percent above full scale");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == blm_pkg::S_AVG || state_r == blm_pkg::S_PCT))
    else $error("divider finished outside a divide state");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == blm_pkg::S_MUL)
    else $error("multiplier finished outside the multiply state");

  a_pct_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == blm_pkg::S_PCT && div_done) |-> div_quot[blm_pkg::PCT_W-1:0] <= blm_pkg::PCT_FULL)
    else $error("percentage quotient out of range");

endmodule
